// ===== src/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int CFG_W     = 32;  // widest configuration register
   localparam int CSR_IDX_W = 2;
   localparam int LG_W      = 4;
   localparam int CNT_W     = 9;
   localparam int STATUS_W  = 3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_LOG2  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_COUNT = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0] POOL_BASE_RST  = 32'd0;
   localparam logic [LG_W-1:0]  SLOT_LOG2_RST  = 4'd2;
   localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 9'd256;

   // Legal slot size range, log2 of bytes.
   localparam logic [LG_W-1:0] LG_MIN = 4'd2;
   localparam logic [LG_W-1:0] LG_MAX = 4'd12;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_EXEC = 3'b100
   } fbpa_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch;  // capture the request payload
      logic look;   // resolve slot index, read link memory
      logic exec;   // update list state, write memory, load result
   } fbpa_cmd_type;

endpackage

// ===== src/fbpa_req_if.sv =====
// Request and response channel interfaces of the block pool allocator.
`timescale 1ns / 1ps

interface fbpa_req_if #(parameter int ADDR_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [ADDR_WIDTH-1:0] address;

   modport source (output valid, output kind, output address, input ready);
   modport sink   (input valid, input kind, input address, output ready);
endinterface

interface fbpa_rsp_if #(parameter int ADDR_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [ADDR_WIDTH-1:0] granted_address;
   logic [8:0]            free_count;
   logic                  pool_full;
   logic                  pool_empty;

   modport source (output valid, output status, output granted_address, output free_count,
                   output pool_full, output pool_empty, input ready);
   modport sink   (input valid, input status, input granted_address, input free_count,
                   input pool_full, input pool_empty, output ready);
endinterface

// ===== src/fbpa_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

// ===== src/fbpa_ctrl.sv =====
// Sequencing state machine of the block pool allocator.
`timescale 1ns / 1ps

module fbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fbpa_pkg::fbpa_cmd_type cmd
);
   import fbpa_pkg::*;

   fbpa_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Result register can take a new result when empty or drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/fbpa_datapath.sv =====
// Datapath: configuration, free list state, link memory and result register.
`timescale 1ns / 1ps

module fbpa_datapath #(
   parameter int MAX_SLOTS  = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpa_pkg::fbpa_cmd_type              cmd,
   input  logic                                csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                req_kind,
   input  logic [ADDR_WIDTH-1:0]               req_address,
   output logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ADDR_WIDTH-1:0]               rsp_granted_address,
   output logic [fbpa_pkg::CNT_W-1:0]          rsp_free_count,
   output logic                                rsp_pool_full,
   output logic                                rsp_pool_empty
);
   import fbpa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int ENT_W = IDX_W + 1;              // on-list bit over link
   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W + 1 : CNT_W + 1;

   // Configuration registers.
   logic [CFG_W-1:0] base_ff;
   logic [LG_W-1:0]  lg_ff;
   logic [CNT_W-1:0] count_ff;
   logic             reinit;

   // Free list state. Memory entries below the watermark are always written.
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] wm_ff, wm_in;

   // Request and lookup registers.
   logic                  kind_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  outside_ff;
   logic                  from_list_ff;
   logic                  from_wm_ff;

   logic [LG_W-1:0]       eff_lg;
   logic [CNT_W-1:0]      eff_count;
   logic [ADDR_WIDTH-1:0] base_a;
   logic [ADDR_WIDTH-1:0] slot_off;
   logic                  outside;
   logic                  from_list;
   logic                  from_wm;
   logic [IDX_W-1:0]      look_idx;

   logic [ENT_W-1:0]      rd_ent;
   logic [IDX_W-1:0]      rd_link;
   logic                  rd_on;
   logic                  below_wm;
   logic                  mem_we;
   logic [ENT_W-1:0]      mem_wdata;
   logic [STATUS_W-1:0]   status_in;
   logic                  granted_ok;
   logic [CNT_W-1:0]      free_in;

   // ---------------- configuration ----------------
   always_comb begin
      if (lg_ff < LG_MIN) begin
         eff_lg = LG_MIN;
      end else if (lg_ff > LG_MAX) begin
         eff_lg = LG_MAX;
      end else begin
         eff_lg = lg_ff;
      end
   end

   assign eff_count = (32'(count_ff) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : count_ff;
   assign base_a    = ADDR_WIDTH'(base_ff);

   always_comb begin
      unique case (csr_index)
         REG_POOL_BASE, REG_SLOT_LOG2, REG_SLOT_COUNT: reinit = csr_we;
         default:                                      reinit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= POOL_BASE_RST;
         lg_ff    <= SLOT_LOG2_RST;
         count_ff <= SLOT_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POOL_BASE:  base_ff  <= csr_wdata;
            REG_SLOT_LOG2:  lg_ff    <= csr_wdata[LG_W-1:0];
            REG_SLOT_COUNT: count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- lookup stage ----------------
   assign slot_off  = (addr_ff - base_a) >> eff_lg;
   assign outside   = (addr_ff < base_a) || (slot_off >= ADDR_WIDTH'(eff_count));
   assign from_list = len_ff != '0;
   assign from_wm   = wm_ff < eff_count;

   always_comb begin
      if (kind_ff == KIND_FREE) begin
         look_idx = IDX_W'(slot_off);
      end else if (from_list) begin
         look_idx = head_ff;
      end else begin
         look_idx = IDX_W'(wm_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
      end
      if (cmd.look) begin
         idx_ff       <= look_idx;
         outside_ff   <= outside;
         from_list_ff <= from_list;
         from_wm_ff   <= from_wm;
      end
   end

   fbpa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_SLOTS)
   ) u_link_ram (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (idx_ff),
      .wdata    (mem_wdata),
      .re       (cmd.look),
      .raddr    (look_idx),
      .rdata_ff (rd_ent)
   );

   // ---------------- execute stage ----------------
   assign rd_link  = rd_ent[IDX_W-1:0];
   assign rd_on    = rd_ent[IDX_W];
   assign below_wm = CMP_W'(idx_ff) < CMP_W'(wm_ff);

   always_comb begin
      head_in    = head_ff;
      len_in     = len_ff;
      wm_in      = wm_ff;
      mem_we     = 1'b0;
      mem_wdata  = '0;
      granted_ok = 1'b0;
      status_in  = ST_NONE_FREE;
      if (kind_ff == KIND_ALLOC) begin
         if (from_list_ff) begin
            // pop the head; keep the head when the list runs dry
            status_in  = ST_ALLOCATED;
            granted_ok = 1'b1;
            len_in     = len_ff - CNT_W'(1);
            if (len_ff != CNT_W'(1)) begin
               head_in = rd_link;
            end
            mem_we    = cmd.exec;
            mem_wdata = {1'b0, rd_link};
         end else if (from_wm_ff) begin
            // first hand-out of a slot: clears its on-list bit
            status_in  = ST_ALLOCATED;
            granted_ok = 1'b1;
            wm_in      = wm_ff + CNT_W'(1);
            mem_we     = cmd.exec;
            mem_wdata  = '0;
         end
      end else begin
         if (outside_ff) begin
            status_in = ST_OUTSIDE;
         end else if (!below_wm || rd_on) begin
            status_in = ST_ALREADY_FREE;
         end else begin
            status_in = ST_FREED;
            head_in   = idx_ff;
            len_in    = len_ff + CNT_W'(1);
            mem_we    = cmd.exec;
            mem_wdata = {1'b1, (len_ff != '0) ? head_ff : IDX_W'(0)};
         end
      end
   end

   // free = never handed out + waiting on the list
   assign free_in = eff_count - wm_in + len_in;

   always_ff @(posedge clock) begin
      if (reset || reinit) begin
         head_ff <= '0;
         len_ff  <= '0;
         wm_ff   <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         len_ff  <= len_in;
         wm_ff   <= wm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status          <= status_in;
         rsp_granted_address <= granted_ok ?
                                base_a + (ADDR_WIDTH'(idx_ff) << eff_lg) : '0;
         rsp_free_count      <= free_in;
         rsp_pool_full       <= free_in == '0;
         rsp_pool_empty      <= free_in == eff_count;
      end
   end

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: controller, datapath, channel ports.
`timescale 1ns / 1ps

// Sequence: the request transfer, a lookup state that reads the link memory, then an execute
//   state that updates the list and loads the result; a new request is taken only when idle;
//   a result waiting on rsp_ready holds the update stage but not the next request capture.
// Reset: synchronous, active high; registers return to base 0, slot size 4 bytes,
//   256 slots, all free. Any register write re-initializes the pool at once, no sweep.
module fixed_block_pool_allocator #(
   parameter int MAX_SLOTS  = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   fbpa_req_if.sink                       req_chan,
   fbpa_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbpa_pkg::CFG_W-1:0]     csr_wdata
);
   import fbpa_pkg::*;

   fbpa_cmd_type cmd;

   // Controller: request transfer -> lookup -> execute, result register valid flag.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Datapath: LIFO free list over a link memory plus an ascending watermark
   // for slots never handed out.
   fbpa_datapath #(
      .MAX_SLOTS  (MAX_SLOTS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_kind            (req_chan.kind),
      .req_address         (req_chan.address),
      .rsp_status          (rsp_chan.status),
      .rsp_granted_address (rsp_chan.granted_address),
      .rsp_free_count      (rsp_chan.free_count),
      .rsp_pool_full       (rsp_chan.pool_full),
      .rsp_pool_empty      (rsp_chan.pool_empty)
   );

endmodule

// ===== tb/sv/fixed_block_pool_allocator_test.sv =====
// Self-checking testbench for the fixed block pool allocator.
`timescale 1ns / 1ps

import fbpa_pkg::*;

localparam int POOL_SLOTS = 256;  // matches the block's MAX_SLOTS

// One response transfer as the checker sees it.
typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [31:0]         granted;
   logic [CNT_W-1:0]    free_count;
   logic                full;
   logic                empty;
} pool_outcome_type;

// Shadow of the pool: mirrors the free list and the registers, predicts every
// response at request transfer and checks responses in order.
class free_list_shadow;
   logic [31:0]      base_addr;
   logic [LG_W-1:0]  size_log2;
   logic [CNT_W-1:0] count_reg;
   logic [7:0]       next_slot [POOL_SLOTS];
   bit               listed [POOL_SLOTS];
   int unsigned      head;
   int unsigned      list_len;
   int unsigned      watermark;
   int unsigned      free_slots;
   pool_outcome_type pending_outcomes [$];
   int unsigned      rsp_transfers;
   int unsigned      error_count;

   function new();
      base_addr     = POOL_BASE_RST;
      size_log2     = SLOT_LOG2_RST;
      count_reg     = SLOT_COUNT_RST;
      rsp_transfers = 0;
      error_count   = 0;
      clear_pool();
   endfunction

   // Usable slots: register capped at the pool depth.
   function int unsigned slot_limit();
      return (count_reg > POOL_SLOTS) ? POOL_SLOTS : count_reg;
   endfunction

   // Slot size is clamped into the legal range.
   function int unsigned slot_shift();
      if (size_log2 < LG_MIN) return LG_MIN;
      if (size_log2 > LG_MAX) return LG_MAX;
      return size_log2;
   endfunction

   function void clear_pool();
      foreach (listed[i]) begin
         listed[i]    = 1'b0;
         next_slot[i] = '0;
      end
      head       = 0;
      list_len   = 0;
      watermark  = 0;
      free_slots = slot_limit();
   endfunction

   // Any register write restarts the pool with every slot free.
   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
         REG_POOL_BASE:  base_addr = data;
         REG_SLOT_LOG2:  size_log2 = data[LG_W-1:0];
         REG_SLOT_COUNT: count_reg = data[CNT_W-1:0];
         default: return;
      endcase
      clear_pool();
   endfunction

   function int unsigned pending();
      return pending_outcomes.size();
   endfunction

   function void predict_outcome(logic kind, logic [31:0] addr);
      pool_outcome_type r;
      int unsigned      limit;
      int unsigned      shift;
      int unsigned      idx;
      logic [31:0]      slot;
      bit               got;
      limit = slot_limit();
      shift = slot_shift();
      r     = '0;
      got   = 1'b0;
      idx   = 0;
      if (kind == KIND_ALLOC) begin
         // freed slots first (LIFO), then the never-used slots in ascending order
         if (list_len > 0) begin
            idx         = head;
            listed[idx] = 1'b0;
            list_len--;
            if (list_len > 0) head = next_slot[idx];
            got = 1'b1;
         end else if (watermark < limit) begin
            idx = watermark;
            watermark++;
            got = 1'b1;
         end
         if (got) begin
            if (free_slots > 0) free_slots--;
            r.granted = base_addr + (32'(idx) << shift);
            r.status  = ST_ALLOCATED;
         end else begin
            r.status = ST_NONE_FREE;
         end
      end else if (addr < base_addr) begin
         r.status = ST_OUTSIDE;
      end else begin
         slot = (addr - base_addr) >> shift;
         if (slot >= limit) begin
            r.status = ST_OUTSIDE;
         end else begin
            idx = slot;
            if (idx >= watermark || listed[idx]) begin
               r.status = ST_ALREADY_FREE;
            end else begin
               next_slot[idx] = (list_len > 0) ? 8'(head) : 8'd0;
               head           = idx;
               listed[idx]    = 1'b1;
               list_len++;
               if (free_slots < limit) free_slots++;
               r.status = ST_FREED;
            end
         end
      end
      r.free_count = free_slots[CNT_W-1:0];
      r.full       = (free_slots == 0);
      r.empty      = (free_slots == limit);
      pending_outcomes.push_back(r);
   endfunction

   task flag_mismatch(string detail);
      error_count++;
      $display("ERROR rsp transfer %0d: %s", rsp_transfers, detail);
   endtask

   task check_outcome(pool_outcome_type seen);
      pool_outcome_type want;
      rsp_transfers++;
      if (pending_outcomes.size() == 0) begin
         flag_mismatch($sformatf("response with nothing pending, status %0d", seen.status));
         return;
      end
      want = pending_outcomes.pop_front();
      if (seen.status !== want.status)
         flag_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
      if (seen.granted !== want.granted)
         flag_mismatch($sformatf("granted_address %h, want %h", seen.granted, want.granted));
      if (seen.free_count !== want.free_count)
         flag_mismatch($sformatf("free_count %0d, want %0d", seen.free_count,
                                 want.free_count));
      if (seen.full !== want.full)
         flag_mismatch($sformatf("pool_full %b, want %b", seen.full, want.full));
      if (seen.empty !== want.empty)
         flag_mismatch($sformatf("pool_empty %b, want %b", seen.empty, want.empty));
   endtask
endclass

module fixed_block_pool_allocator_test;

   localparam int CYCLE_LIMIT   = 400_000;  // far beyond the slowest legal run
   localparam int PHASE_ITEMS   = 160;
   localparam int RANDOM_PHASES = 12;
   localparam int HOLD_CYCLES   = 300;      // long response back-pressure stretch

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   fbpa_req_if #(.ADDR_WIDTH(32)) req_bus ();
   fbpa_rsp_if #(.ADDR_WIDTH(32)) rsp_bus ();

   free_list_shadow pool = new();

   bit steady;            // no idling on either side while set
   int rsp_hold_cycles;   // receiver holds ready low while nonzero
   int cycle_count;

   fixed_block_pool_allocator #(
      .MAX_SLOTS  (POOL_SLOTS),
      .ADDR_WIDTH (32)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: check each transfer, then pick ready for the next cycle.
   // Signals are sampled right after the edge, i.e. the values the block saw.
   initial begin
      pool_outcome_type seen;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen.status     = rsp_bus.status;
            seen.granted    = rsp_bus.granted_address;
            seen.free_count = rsp_bus.free_count;
            seen.full       = rsp_bus.pool_full;
            seen.empty      = rsp_bus.pool_empty;
            pool.check_outcome(seen);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 30);
         end
      end
   end

   // One request transfer, with an optional idle gap ahead of it.
   // valid stays high across back-to-back transfers.
   task automatic send_request(input logic kind, input logic [31:0] addr);
      if (!steady && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      pool.predict_outcome(kind, addr);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pool.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program all three registers back to back on an idle block.
   task automatic load_config(input logic [31:0] base_v, input logic [31:0] lg_v,
                              input logic [31:0] count_v);
      settle();
      csr_we    <= 1'b1;
      csr_index <= REG_POOL_BASE;
      csr_wdata <= base_v;
      @(posedge clock);
      csr_index <= REG_SLOT_LOG2;
      csr_wdata <= lg_v;
      @(posedge clock);
      csr_index <= REG_SLOT_COUNT;
      csr_wdata <= count_v;
      @(posedge clock);
      csr_we <= 1'b0;
      pool.write_reg(REG_POOL_BASE, base_v);
      pool.write_reg(REG_SLOT_LOG2, lg_v);
      pool.write_reg(REG_SLOT_COUNT, count_v);
   endtask

   // Allocate or free by alloc_pct; frees mostly hit slots already handed out (random byte
   // inside the slot), plus double frees of the list head, pool edges and raw noise.
   function automatic void make_request(input int alloc_pct, output logic kind,
                                        output logic [31:0] addr);
      int unsigned shift;
      int unsigned limit;
      int unsigned pick;
      logic [31:0] span_mask;
      logic [31:0] pool_end;
      shift     = pool.slot_shift();
      limit     = pool.slot_limit();
      span_mask = (32'd1 << shift) - 32'd1;
      pool_end  = pool.base_addr + (32'(limit) << shift);
      addr      = $urandom;
      kind      = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
      if (kind == KIND_FREE) begin
         pick = $urandom_range(0, 99);
         if (pick < 70 && pool.watermark > 0) begin
            addr = pool.base_addr + (32'($urandom_range(0, pool.watermark - 1)) << shift)
                   + (addr & span_mask);
         end else if (pick < 80 && pool.list_len > 0) begin
            addr = pool.base_addr + (32'(pool.head) << shift);
         end else if (pick < 90) begin
            case ($urandom_range(0, 2))
               0:       addr = pool_end;              // one slot past the end
               1:       addr = pool_end - 32'd1;      // last byte of the last slot
               default: addr = pool.base_addr - 32'd1;  // just below the base
            endcase
         end
      end
   endfunction

   // Reset values first, then LIFO reuse, rounding, both pool edges,
   // a full two-slot pool and an empty pool.
   task automatic run_directed();
      send_request(KIND_ALLOC, 32'hFFFF_FFFF);  // address ignored on allocate
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_FREE, 32'h4);
      send_request(KIND_FREE, 32'h7);           // rounds down onto a free slot
      send_request(KIND_ALLOC, 32'h0);          // most recent free comes back
      send_request(KIND_FREE, 32'h8);
      send_request(KIND_FREE, 32'h0);
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_ALLOC, 32'h0);          // watermark slot
      send_request(KIND_FREE, 32'h3FF);         // last slot, never handed out
      send_request(KIND_FREE, 32'h400);         // first byte past the pool
      send_request(KIND_FREE, 32'hFFFF_FFFF);
      load_config(32'h100, 32'd3, 32'd2);
      send_request(KIND_FREE, 32'hFF);          // below the base
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_ALLOC, 32'h0);          // pool full
      send_request(KIND_FREE, 32'h10F);
      send_request(KIND_FREE, 32'h100);         // every slot free again
      send_request(KIND_ALLOC, 32'h0);
      load_config(32'h100, 32'd3, 32'd0);       // pool with no slots
      send_request(KIND_ALLOC, 32'h0);
      send_request(KIND_FREE, 32'h100);
   endtask

   task automatic run_phase(input int phase);
      logic [31:0] base_v;
      logic [31:0] lg_v;
      logic [31:0] count_v;
      logic        kind;
      logic [31:0] addr;
      case (phase)
         0: begin base_v = 32'h0;         lg_v = 32'd2;  count_v = 32'd256; end
         1: begin base_v = 32'hFFFF_F000; lg_v = 32'd15; count_v = 32'd511; end
         2: begin base_v = 32'hFFFF_FFFF; lg_v = 32'd0;  count_v = 32'd1;   end
         3: begin base_v = 32'h8000_0000; lg_v = 32'd12; count_v = 32'd0;   end
         default: begin
            base_v = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
            lg_v   = ($urandom & 32'hFFFF_FFF0) | 32'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: count_v = 32'($urandom_range(1, 16));
               5, 6, 7:       count_v = 32'($urandom_range(17, 300));
               default:       count_v = 32'($urandom_range(0, 511));
            endcase
            count_v = count_v | ($urandom & 32'hFFFF_FE00);
         end
      endcase
      load_config(base_v, lg_v, count_v);
      steady = (phase == 5);
      if (phase == 6) rsp_hold_cycles = HOLD_CYCLES;  // input side keeps offering
      // allocation-heavy first half fills the pool, free-heavy second half drains it
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (phase == 7 && n == PHASE_ITEMS / 2) settle();
         make_request((n < PHASE_ITEMS / 2) ? 70 : 35, kind, addr);
         send_request(kind, addr);
      end
      steady = 1'b0;
   endtask

   initial begin
      steady          = 1'b0;
      rsp_hold_cycles = 0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= REG_POOL_BASE;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= KIND_ALLOC;
      req_bus.address <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < RANDOM_PHASES; p++) run_phase(p);
      settle();
      repeat (10) @(posedge clock);  // catch any stray response
      if (pool.error_count == 0 && pool.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
src/fbpa_pkg.sv
src/fbpa_req_if.sv
src/fbpa_ram.sv
src/fbpa_ctrl.sv
src/fbpa_datapath.sv
src/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
